// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication property checked on every rising clock edge out of reset
`define CHK_IMPLY(label, clk, rstn, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication property
`define CHK_NEXT(label, clk, rstn, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

// ===== rtl/bfiq_pkg.sv =====
`default_nettype none
package bfiq_pkg;
  localparam int unsigned MAX_FILTER_BITS = 65536;
  localparam int unsigned MAX_PROBES      = 30;
  localparam int unsigned MAX_KEY_LENGTH  = 65535;
  localparam int unsigned MIN_FILTER_BITS = 64;

  localparam logic [31:0] SEED_FIRST  = 32'h9747b28c;
  localparam logic [31:0] SEED_SECOND = 32'h5bd1e995;
  localparam logic [31:0] HASH_MUL    = 32'h5bd1e995;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic CFG_BITS   = 1'b0;
  localparam logic CFG_PROBES = 1'b1;

  // commands from controller to datapath
  typedef struct packed {
    logic seed;      // load seeds from the beat's length
    logic absorb;    // hash the beat's byte
    logic cap_beat;  // capture the input beat
    logic pinit;     // start the probe sequence
    logic div_start; // start the modulo unit
    logic rd;        // issue a store read
    logic wr;        // write back the set bit
    logic fail;      // record a miss
    logic clr_wr;    // write zero at the sweep address
    logic clr_init;  // rewind the sweep address
    logic pnext;     // advance to the next probe
    logic emit;      // present the result beat
  } bfiq_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic div_done;
    logic bit_set;
    logic probes_left;
    logic clr_last;
  } bfiq_sts_t;
endpackage
`default_nettype wire

// ===== rtl/bfiq_ram.sv =====
`default_nettype none
module bfiq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8192
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [WIDTH-1:0]         wdata,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/bfiq_ctrl.sv =====
`default_nettype none
module bfiq_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  input  wire [1:0]          in_operation,
  input  wire [15:0]         in_key_length,
  input  wire                in_last,
  input  wire bfiq_pkg::bfiq_sts_t sts,
  output bfiq_pkg::bfiq_cmd_t     cmd,
  output logic               busy
);
  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_CHK  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       inside_r, inside_nxt;
  logic [1:0] op_r, op_nxt;

  assign busy = (state_r != S_IDLE);

  // sequence one beat: hash, then probes or a clearing sweep
  always_comb begin
    state_nxt  = state_r;
    inside_nxt = inside_r;
    op_nxt     = op_r;
    cmd        = '0;
    unique case (state_r)
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = (op_r == bfiq_pkg::OP_CLEAR) ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (start && in_operation != bfiq_pkg::OP_NONE) begin
          op_nxt       = in_operation;
          cmd.cap_beat = 1'b1;
          if (in_operation == bfiq_pkg::OP_CLEAR) begin
            inside_nxt   = 1'b0;
            cmd.clr_init = 1'b1;
            state_nxt    = S_CLR;
          end else begin
            cmd.seed   = !inside_r;
            cmd.absorb = (in_key_length != 16'd0);
            inside_nxt = !in_last;
            if (in_last) begin
              cmd.pinit = 1'b1;
              state_nxt = S_DIV;
            end
          end
        end
      end
      S_DIV: begin
        if (!sts.probes_left) begin
          state_nxt = S_DONE;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_RD;
        end
      end
      S_RD: begin
        if (sts.div_done) begin
          cmd.rd    = 1'b1;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        cmd.pnext = 1'b1;
        state_nxt = S_DIV;
        if (op_r == bfiq_pkg::OP_INSERT) begin
          cmd.wr = 1'b1;
        end else if (!sts.bit_set) begin
          cmd.fail  = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state registers; reset runs the clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLR;
      inside_r <= 1'b0;
      op_r     <= bfiq_pkg::OP_NONE;
    end else begin
      state_r  <= state_nxt;
      inside_r <= inside_nxt;
      op_r     <= op_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/bfiq_dp.sv =====
`default_nettype none
module bfiq_dp #(
  parameter int unsigned MAX_FILTER_BITS = bfiq_pkg::MAX_FILTER_BITS,
  parameter int unsigned MAX_PROBES      = bfiq_pkg::MAX_PROBES
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire bfiq_pkg::bfiq_cmd_t cmd,
  output bfiq_pkg::bfiq_sts_t      sts,
  input  wire [1:0]           in_operation,
  input  wire [7:0]           in_key_byte,
  input  wire [15:0]          in_key_length,
  input  wire                 cfg_we,
  input  wire                 cfg_index,
  input  wire [16:0]          cfg_data,
  output logic                out_valid,
  output logic [1:0]          out_done_operation,
  output logic                out_may_contain
);
  localparam int unsigned BW    = $clog2(MAX_FILTER_BITS + 1);
  localparam int unsigned DEPTH = (MAX_FILTER_BITS + 7) / 8;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned PW    = $clog2(MAX_PROBES + 1);

  logic [BW-1:0] bits_r;
  logic [PW-1:0] probes_r;
  logic [31:0]   h1_r, h2_r, pos_r;
  logic [PW-1:0] pidx_r;
  logic [1:0]    op_r;
  logic          maybe_r;
  logic [AW-1:0] clr_r, addr_r;
  logic [2:0]    bsel_r;
  logic          out_valid_r;
  logic [1:0]    out_op_r;
  logic          out_may_r;
  logic [7:0]    rdata;
  // modulo unit: restoring, one quotient bit per cycle
  logic [31:0]   rem_r;
  logic [31:0]   quo_r;
  logic [5:0]    dcnt_r;
  logic          dbusy_r;

  // saturate a written modulus
  function automatic logic [BW-1:0] clamp_bits(input logic [16:0] v);
    if ({15'd0, v} < 32'(bfiq_pkg::MIN_FILTER_BITS)) return BW'(bfiq_pkg::MIN_FILTER_BITS);
    if ({15'd0, v} > 32'(MAX_FILTER_BITS)) return BW'(MAX_FILTER_BITS);
    return BW'(v);
  endfunction

  function automatic logic [31:0] mix(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] m;
    m = (h ^ {24'd0, b}) * bfiq_pkg::HASH_MUL;
    return m ^ (m >> 15);
  endfunction

  logic [32:0] trial;
  assign trial = {rem_r[31:0], quo_r[31]} - {1'b0, 32'(bits_r)};

  assign sts.div_done    = dbusy_r && (dcnt_r == 6'd0);
  assign sts.bit_set     = rdata[bsel_r];
  assign sts.probes_left = (pidx_r < probes_r);
  assign sts.clr_last    = (clr_r == AW'(DEPTH - 1));

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r   <= BW'(MAX_FILTER_BITS);
      probes_r <= PW'(7);
    end else if (cfg_we) begin
      if (cfg_index == bfiq_pkg::CFG_BITS) begin
        bits_r <= clamp_bits(cfg_data);
      end else begin
        probes_r <= ({12'd0, cfg_data[4:0]} > 17'(MAX_PROBES)) ? PW'(MAX_PROBES)
                                                               : PW'(cfg_data[4:0]);
      end
    end
  end

  // hashes and sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h1_r  <= '0;
      h2_r  <= '0;
      clr_r <= '0;
    end else begin
      if (cmd.absorb) begin
        h1_r <= mix(cmd.seed ? (bfiq_pkg::SEED_FIRST ^ {16'd0, in_key_length}) : h1_r,
                    in_key_byte);
        h2_r <= mix(cmd.seed ? (bfiq_pkg::SEED_SECOND ^ {16'd0, in_key_length}) : h2_r,
                    in_key_byte);
      end else if (cmd.seed) begin
        h1_r <= bfiq_pkg::SEED_FIRST ^ {16'd0, in_key_length};
        h2_r <= bfiq_pkg::SEED_SECOND ^ {16'd0, in_key_length};
      end
      if (cmd.clr_init) clr_r <= '0;
      else if (cmd.clr_wr) clr_r <= clr_r + AW'(1);
    end
  end

  // probe walk: pos advances by h2 each probe
  always_ff @(posedge clk) begin
    if (cmd.cap_beat) op_r <= in_operation;
    if (cmd.pinit) begin
      pidx_r  <= '0;
      maybe_r <= 1'b1;
      pos_r   <= cmd.absorb ? mix(cmd.seed ? (bfiq_pkg::SEED_FIRST ^ {16'd0, in_key_length})
                                           : h1_r, in_key_byte)
                            : (cmd.seed ? (bfiq_pkg::SEED_FIRST ^ {16'd0, in_key_length})
                                        : h1_r);
    end
    if (cmd.pnext) begin
      pidx_r <= pidx_r + PW'(1);
      pos_r  <= pos_r + h2_r;
    end
    if (cmd.fail) maybe_r <= 1'b0;
  end

  // modulo unit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0;
      dcnt_r  <= '0;
    end else if (cmd.div_start) begin
      dbusy_r <= 1'b1;
      dcnt_r  <= 6'd32;
      rem_r   <= '0;
      quo_r   <= pos_r;
    end else if (dbusy_r && dcnt_r != 6'd0) begin
      dcnt_r <= dcnt_r - 6'd1;
      quo_r  <= {quo_r[30:0], 1'b0};
      rem_r  <= trial[32] ? {rem_r[30:0], quo_r[31]} : trial[31:0];
    end else if (cmd.rd) begin
      dbusy_r <= 1'b0;
      addr_r  <= AW'(rem_r >> 3);
      bsel_r  <= rem_r[2:0];
    end
  end

  logic [AW-1:0] raddr, waddr;
  logic          we;
  logic [7:0]    wdata;
  assign raddr = AW'(rem_r >> 3);
  assign we    = cmd.clr_wr || cmd.wr;
  assign waddr = cmd.clr_wr ? clr_r : addr_r;
  assign wdata = cmd.clr_wr ? 8'd0 : (rdata | (8'd1 << bsel_r));

  bfiq_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
    if (cmd.emit) begin
      out_op_r  <= op_r;
      out_may_r <= (op_r == bfiq_pkg::OP_QUERY) && maybe_r && !cmd.fail;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_done_operation = out_op_r;
  assign out_may_contain    = out_may_r;
endmodule
`default_nettype wire

// ===== rtl/bloom_filter_insert_query_top.sv =====
// Byte beats are taken from idle; a last beat then runs the probes, a query stopping
// at its first miss. The probe modulo is a 32-step restoring divider, one bit per cycle.
// A clear sweeps the 8-bit store, one byte per cycle.
// Reset (rst_n low, synchronous) starts the same sweep; busy stays high until done.
// The result strobe out_valid is high one cycle; the receiver cannot stall.
`default_nettype none
module bloom_filter_insert_query_top #(
  parameter int unsigned MAX_FILTER_BITS = bfiq_pkg::MAX_FILTER_BITS,
  parameter int unsigned MAX_PROBES      = bfiq_pkg::MAX_PROBES
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        start,
  output logic       busy,
  input  wire [1:0]  in_operation,
  input  wire [7:0]  in_key_byte,
  input  wire [15:0] in_key_length,
  input  wire        in_last,
  input  wire        cfg_we,
  input  wire        cfg_index,
  input  wire [16:0] cfg_data,
  output logic       out_valid,
  output logic [1:0] out_done_operation,
  output logic       out_may_contain
);
  bfiq_pkg::bfiq_cmd_t cmd;
  bfiq_pkg::bfiq_sts_t sts;

  bfiq_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .in_operation(in_operation),
    .in_key_length(in_key_length), .in_last(in_last), .sts(sts), .cmd(cmd), .busy(busy)
  );

  bfiq_dp #(.MAX_FILTER_BITS(MAX_FILTER_BITS), .MAX_PROBES(MAX_PROBES)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .in_operation(in_operation),
    .in_key_byte(in_key_byte), .in_key_length(in_key_length), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .out_valid(out_valid),
    .out_done_operation(out_done_operation), .out_may_contain(out_may_contain)
  );
endmodule
`default_nettype wire

// ===== rtl/bfiq_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module bfiq_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       start,
  input wire       busy,
  input wire [1:0] in_operation,
  input wire       out_valid,
  input wire [1:0] out_done_operation,
  input wire       out_may_contain
);
  // only queries may report a possible hit
  `CHK_IMPLY(a_may_query, clk, rst_n, out_valid && out_may_contain, out_done_operation == bfiq_pkg::OP_QUERY)
  // results are single-cycle strobes
  `CHK_NEXT(a_strobe, clk, rst_n, out_valid, !out_valid)
  // a clear beat keeps the block busy
  `CHK_NEXT(a_clr_busy, clk, rst_n, start && !busy && in_operation == bfiq_pkg::OP_CLEAR, busy)
  // no result appears while idle without work
  `CHK_IMPLY(a_no_idle_out, clk, rst_n, out_valid, !$past(!busy && !start))
endmodule

bind bloom_filter_insert_query_top bfiq_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_operation(in_operation),
  .out_valid(out_valid), .out_done_operation(out_done_operation),
  .out_may_contain(out_may_contain)
);
`default_nettype wire

// ===== bench/tb_top.sv =====
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 60000000;

  typedef struct packed {
    logic [1:0] op;
    logic       maybe;
  } bloom_answer_t;

  typedef struct {
    int unsigned len;
    logic [7:0]  bytes[8];
  } bloom_key_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_operation;
  logic [7:0]  in_key_byte;
  logic [15:0] in_key_length;
  logic        in_last;
  logic        cfg_we;
  logic        cfg_index;
  logic [16:0] cfg_data;
  logic        out_valid;
  logic [1:0]  out_done_operation;
  logic        out_may_contain;

  bloom_filter_insert_query_top DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_key_byte(in_key_byte),
    .in_key_length(in_key_length), .in_last(in_last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_done_operation(out_done_operation),
    .out_may_contain(out_may_contain)
  );

  // Mirror of the filter state
  logic          filter_bit[bfiq_pkg::MAX_FILTER_BITS];
  logic [31:0]   hash_a;
  logic [31:0]   hash_b;
  logic          key_open;
  logic [16:0]   modulus_bits;
  logic [4:0]    probes;
  bloom_answer_t pending_answers[$];
  bloom_key_t    key_pool[$];
  int unsigned   fail_count;
  int unsigned   beat_count;
  int unsigned   idle_pct;
  int unsigned   cycle_count;
  logic          busy_s;

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // Sample busy mid-cycle so the edge decision never races
  always @(negedge clk) busy_s <= busy;

  // Hard stop
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic logic [31:0] mix_byte(logic [31:0] h, logic [7:0] b);
    logic [63:0] prod;
    h = h ^ {24'd0, b};
    prod = {32'd0, h} * {32'd0, bfiq_pkg::HASH_MUL};
    h = prod[31:0];
    return h ^ (h >> 15);
  endfunction

  task automatic wipe_filter();
    for (int i = 0; i < bfiq_pkg::MAX_FILTER_BITS; i++) filter_bit[i] = 1'b0;
  endtask

  // Advance the mirror by one accepted beat, queue any answer
  task automatic predict_beat(logic [1:0] op, logic [7:0] kb, logic [15:0] len, logic lst);
    logic [31:0]   pos;
    logic [63:0]   prod;
    int unsigned   bitn;
    logic          hit;
    bloom_answer_t ans;
    if (op == bfiq_pkg::OP_NONE) return;
    if (op == bfiq_pkg::OP_CLEAR) begin
      wipe_filter();
      key_open = 1'b0;
      ans.op = bfiq_pkg::OP_CLEAR;
      ans.maybe = 1'b0;
      pending_answers.push_back(ans);
      return;
    end
    if (!key_open) begin
      hash_a = bfiq_pkg::SEED_FIRST ^ {16'd0, len};
      hash_b = bfiq_pkg::SEED_SECOND ^ {16'd0, len};
      key_open = 1'b1;
    end
    if (len != 16'd0) begin
      hash_a = mix_byte(hash_a, kb);
      hash_b = mix_byte(hash_b, kb);
    end
    if (!lst) return;
    key_open = 1'b0;
    hit = 1'b1;
    for (int i = 0; i < probes; i++) begin
      prod = 64'(i) * {32'd0, hash_b};
      pos = hash_a + prod[31:0];
      bitn = pos % {15'd0, modulus_bits};
      if (op == bfiq_pkg::OP_INSERT) filter_bit[bitn] = 1'b1;
      else if (!filter_bit[bitn]) begin
        hit = 1'b0;
        break;
      end
    end
    ans.op = op;
    ans.maybe = (op == bfiq_pkg::OP_QUERY) && hit;
    pending_answers.push_back(ans);
  endtask

  // Check each result strobe against the oldest answer
  always @(negedge clk) begin
    bloom_answer_t exp_ans;
    if (rst_n && out_valid) begin
      if (pending_answers.size() == 0) begin
        $display("%0t unexpected result: op %0d maybe %0d", $realtime,
                 out_done_operation, out_may_contain);
        fail_count++;
      end else begin
        exp_ans = pending_answers.pop_front();
        if (out_done_operation !== exp_ans.op) begin
          $display("%0t done_operation: expected %0d actual %0d", $realtime,
                   exp_ans.op, out_done_operation);
          fail_count++;
        end
        if (out_may_contain !== exp_ans.maybe) begin
          $display("%0t may_contain: expected %0d actual %0d", $realtime,
                   exp_ans.maybe, out_may_contain);
          fail_count++;
        end
      end
    end
  end

  // Send one beat, with an optional random gap before it
  task automatic send_beat(logic [1:0] op, logic [7:0] kb, logic [15:0] len, logic lst);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start         <= 1'b1;
    in_operation  <= op;
    in_key_byte   <= kb;
    in_key_length <= len;
    in_last       <= lst;
    do @(posedge clk); while (busy_s);
    predict_beat(op, kb, len, lst);
    if (op != bfiq_pkg::OP_NONE) beat_count++;
  endtask

  // Drop start and drain every outstanding answer
  task automatic drain();
    start <= 1'b0;
    while (pending_answers.size() != 0 || busy_s) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write both registers while the block is idle
  task automatic set_filter(logic [16:0] bits_val, logic [16:0] probe_val);
    drain();
    cfg_we <= 1'b1; cfg_index <= bfiq_pkg::CFG_BITS; cfg_data <= bits_val;
    @(posedge clk);
    cfg_index <= bfiq_pkg::CFG_PROBES; cfg_data <= probe_val;
    @(posedge clk);
    cfg_we <= 1'b0;
    modulus_bits = (bits_val < 17'd64) ? 17'd64 :
                   (bits_val > 17'd65536) ? 17'd65536 : bits_val;
    probes = (probe_val[4:0] > 5'd30) ? 5'd30 : probe_val[4:0];
  endtask

  task automatic send_key(logic [1:0] op, bloom_key_t k, logic [15:0] len);
    for (int i = 0; i < k.len; i++) send_beat(op, k.bytes[i], len, i == k.len - 1);
  endtask

  function automatic bloom_key_t random_key();
    bloom_key_t k;
    k.len = $urandom_range(1, 8);
    foreach (k.bytes[i]) k.bytes[i] = 8'($urandom_range(255));
    return k;
  endfunction

  task automatic test_field_extremes();
    bloom_key_t k;
    k.len = 2;
    k.bytes[0] = 8'h00; k.bytes[1] = 8'hff;
    send_key(bfiq_pkg::OP_INSERT, k, 16'd2);
    send_key(bfiq_pkg::OP_QUERY, k, 16'd2);
    k.bytes[0] = 8'hff; k.bytes[1] = 8'h00;
    send_key(bfiq_pkg::OP_QUERY, k, 16'hffff);
    send_key(bfiq_pkg::OP_INSERT, k, 16'hffff);
    send_key(bfiq_pkg::OP_QUERY, k, 16'hffff);
    // empty keys: byte ignored
    send_beat(bfiq_pkg::OP_INSERT, 8'ha5, 16'd0, 1'b1);
    send_beat(bfiq_pkg::OP_QUERY, 8'h5a, 16'd0, 1'b1);
    send_beat(bfiq_pkg::OP_CLEAR, 8'h00, 16'd0, 1'b0);
    send_key(bfiq_pkg::OP_QUERY, k, 16'hffff);
  endtask

  task automatic test_odd_sequences();
    // unused operation code is ignored
    send_beat(bfiq_pkg::OP_NONE, 8'h12, 16'd3, 1'b1);
    // clear in mid key abandons it
    send_beat(bfiq_pkg::OP_INSERT, 8'h11, 16'd3, 1'b0);
    send_beat(bfiq_pkg::OP_CLEAR, 8'h22, 16'd3, 1'b1);
    send_beat(bfiq_pkg::OP_QUERY, 8'h11, 16'd1, 1'b1);
    // operation changes in mid key: last beat decides
    send_beat(bfiq_pkg::OP_QUERY, 8'h33, 16'd2, 1'b0);
    send_beat(bfiq_pkg::OP_INSERT, 8'h44, 16'd2, 1'b1);
    send_beat(bfiq_pkg::OP_INSERT, 8'h33, 16'd2, 1'b0);
    send_beat(bfiq_pkg::OP_QUERY, 8'h44, 16'd2, 1'b1);
    // length mismatch: first beat's length seeds
    send_beat(bfiq_pkg::OP_INSERT, 8'h55, 16'd1, 1'b0);
    send_beat(bfiq_pkg::OP_INSERT, 8'h66, 16'd9, 1'b0);
    send_beat(bfiq_pkg::OP_INSERT, 8'h77, 16'd4, 1'b1);
    // zero length without last keeps the key open
    send_beat(bfiq_pkg::OP_QUERY, 8'h88, 16'd0, 1'b0);
    send_beat(bfiq_pkg::OP_QUERY, 8'h99, 16'd0, 1'b1);
  endtask

  // Mostly well formed keys from a reused pool, some noise
  task automatic test_random_keys(int unsigned beats);
    bloom_key_t  k;
    int unsigned stop_at;
    int unsigned pick;
    logic [1:0]  op;
    logic [15:0] len;
    stop_at = beat_count + beats;
    while (beat_count < stop_at) begin
      pick = $urandom_range(99);
      if (key_pool.size() == 0 || pick < 30) begin
        k = random_key();
        if (key_pool.size() >= 12) void'(key_pool.pop_front());
        key_pool.push_back(k);
      end else k = key_pool[$urandom_range(key_pool.size() - 1)];
      op = ($urandom_range(1)) ? bfiq_pkg::OP_QUERY : bfiq_pkg::OP_INSERT;
      len = ($urandom_range(9) == 0) ? 16'($urandom) : 16'(k.len);
      pick = $urandom_range(99);
      if (pick < 80) send_key(op, k, len);
      else if (pick < 84) send_beat(op, 8'($urandom_range(255)), 16'd0,
                                    1'($urandom_range(1)));
      else if (pick < 86) send_beat(bfiq_pkg::OP_CLEAR, 8'($urandom_range(255)),
                                    16'($urandom), 1'($urandom_range(1)));
      else if (pick < 91) send_beat(bfiq_pkg::OP_NONE, 8'($urandom_range(255)),
                                    16'($urandom), 1'($urandom_range(1)));
      else if (pick < 93) begin
        // broken key cut by a clear
        send_beat(op, k.bytes[0], len, 1'b0);
        send_beat(bfiq_pkg::OP_CLEAR, 8'h00, 16'd0, 1'b0);
      end else begin
        // operation flips before the end
        for (int i = 0; i < k.len; i++)
          send_beat($urandom_range(1) ? bfiq_pkg::OP_QUERY : bfiq_pkg::OP_INSERT,
                    k.bytes[i], len, i == k.len - 1);
      end
    end
  endtask

  initial begin
    start = 1'b0; in_operation = bfiq_pkg::OP_INSERT; in_key_byte = 8'd0;
    in_key_length = 16'd0; in_last = 1'b0;
    cfg_we = 1'b0; cfg_index = bfiq_pkg::CFG_BITS; cfg_data = 17'd0;
    rst_n = 1'b0;
    fail_count = 0; beat_count = 0; idle_pct = 10; cycle_count = 0;
    hash_a = 32'd0; hash_b = 32'd0; key_open = 1'b0;
    modulus_bits = 17'd65536; probes = 5'd7;
    wipe_filter();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_field_extremes();
    test_odd_sequences();

    set_filter(17'd64, 17'd30);
    test_random_keys(330);
    set_filter(17'd0, 17'd31);
    test_random_keys(330);
    idle_pct = 70;
    set_filter(17'h1ffff, 17'd0);
    test_random_keys(300);
    set_filter(17'd65536, 17'd1);
    test_random_keys(330);
    idle_pct = 0;
    set_filter(17'($urandom_range(64, 1000)), 17'($urandom_range(1, 30)));
    test_random_keys(330);
    set_filter(17'd200, 17'h1ffff);
    test_random_keys(330);

    drain();
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule
`default_nettype wire
